/* rtl/sync_hunting_packet_deframer_unit_macros.svh */
`ifndef SYNC_HUNTING_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_HUNTING_PACKET_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication under synchronous reset
`define SHPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication under synchronous reset
`define SHPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* rtl/shpd_pkg.sv */
package shpd_pkg;

    typedef logic [3:0] t_phase;
    typedef logic [1:0] t_kind;

    localparam t_phase PH_HEADER   = 4'd0;
    localparam t_phase PH_LENGTH   = 4'd1;
    localparam t_phase PH_PAYLOAD  = 4'd2;
    localparam t_phase PH_HUNT     = 4'd3;
    localparam t_phase PH_HLEN     = 4'd4;
    localparam t_phase PH_HSKIP    = 4'd5;
    localparam t_phase PH_HCHECK   = 4'd6;
    localparam t_phase PH_HLEN2    = 4'd7;
    localparam t_phase PH_HDISCARD = 4'd8;

    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_EMPTY   = 2'd1;
    localparam t_kind KIND_RESYNC  = 2'd2;

    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_SYNC_BYTE = 3'd0;

endpackage

/* rtl/sync_hunting_packet_deframer_unit.sv */
// channel   direction  handshake             payload
// rx        in         i_valid / o_ready     i_rx_byte
// result    out        o_valid / i_ready     o_kind, o_payload_byte, o_byte_index,
//                                            o_last, o_packet_length
// config    in         psel/penable/pwrite   paddr, pwdata -> prdata, pready
//
// one byte accepted per cycle unless a held result backs up the input register; a result
// passes from its byte through the input register and then the single state-update stage
// synchronous active-low reset returns to locked, expecting a header byte
// a held result stalls the state stage only; the input register still
// takes a byte whenever it is free or moving on in the same cycle
`include "sync_hunting_packet_deframer_unit_macros.svh"

module sync_hunting_packet_deframer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_payload_byte,
    output logic [7:0]                     o_byte_index,
    output logic                           o_last,
    output logic [7:0]                     o_packet_length,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [shpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [7:0]           r_sync_byte;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    shpd_pkg::t_phase     r_phase, n_phase;
    logic [7:0]           r_bytes_left, n_bytes_left;
    logic [7:0]           r_cur_len, n_cur_len;
    logic [7:0]           r_pos, n_pos;

    logic                 r_out_valid, n_out_valid;
    shpd_pkg::t_kind      r_kind, n_kind;
    logic [7:0]           r_payload_byte, n_payload_byte;
    logic [7:0]           r_byte_index, n_byte_index;
    logic                 r_last, n_last;
    logic [7:0]           r_packet_length, n_packet_length;

    logic                 advance;
    logic                 is_sync;
    logic [7:0]           left_dec;
    logic                 out_payload;
    logic                 out_empty;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == shpd_pkg::REG_SYNC_BYTE[2]) ? {24'd0, r_sync_byte} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte        <= 8'd0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == shpd_pkg::REG_SYNC_BYTE[2]) begin
                r_sync_byte <= pwdata[7:0];
            end
        end
    end

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign is_sync  = (r_in_byte == r_sync_byte);
    assign left_dec = r_bytes_left - 8'd1;

    always_comb begin
        n_phase         = r_phase;
        n_bytes_left    = r_bytes_left;
        n_cur_len       = r_cur_len;
        n_pos           = r_pos;
        n_out_valid     = 1'b0;
        n_kind          = shpd_pkg::KIND_PAYLOAD;
        n_payload_byte  = 8'd0;
        n_byte_index    = 8'd0;
        n_last          = 1'b1;
        n_packet_length = 8'd0;
        case (r_phase)
            shpd_pkg::PH_HEADER: begin
                n_phase = is_sync ? shpd_pkg::PH_LENGTH : shpd_pkg::PH_HUNT;
            end
            shpd_pkg::PH_LENGTH: begin
                n_cur_len = r_in_byte;
                n_pos     = 8'd0;
                if (r_in_byte == 8'd0) begin
                    n_phase     = shpd_pkg::PH_HEADER;
                    n_out_valid = 1'b1;
                    n_kind      = shpd_pkg::KIND_EMPTY;
                end else begin
                    n_bytes_left = r_in_byte;
                    n_phase      = shpd_pkg::PH_PAYLOAD;
                end
            end
            shpd_pkg::PH_PAYLOAD: begin
                n_out_valid     = 1'b1;
                n_kind          = shpd_pkg::KIND_PAYLOAD;
                n_payload_byte  = r_in_byte;
                n_byte_index    = r_pos;
                n_last          = (r_bytes_left <= 8'd1);
                n_packet_length = r_cur_len;
                n_pos           = r_pos + 8'd1;
                n_bytes_left    = left_dec;
                if (r_bytes_left <= 8'd1) begin
                    n_phase = shpd_pkg::PH_HEADER;
                end
            end
            shpd_pkg::PH_HUNT: begin
                if (is_sync) begin
                    n_phase = shpd_pkg::PH_HLEN;
                end
            end
            shpd_pkg::PH_HLEN: begin
                n_bytes_left = r_in_byte;
                n_phase = (r_in_byte == 8'd0) ? shpd_pkg::PH_HCHECK : shpd_pkg::PH_HSKIP;
            end
            shpd_pkg::PH_HSKIP: begin
                n_bytes_left = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = shpd_pkg::PH_HCHECK;
                end
            end
            shpd_pkg::PH_HCHECK: begin
                n_phase = is_sync ? shpd_pkg::PH_HLEN2 : shpd_pkg::PH_HUNT;
            end
            shpd_pkg::PH_HLEN2: begin
                n_cur_len    = r_in_byte;
                n_bytes_left = r_in_byte;
                if (r_in_byte == 8'd0) begin
                    n_phase     = shpd_pkg::PH_HEADER;
                    n_out_valid = 1'b1;
                    n_kind      = shpd_pkg::KIND_RESYNC;
                end else begin
                    n_phase = shpd_pkg::PH_HDISCARD;
                end
            end
            shpd_pkg::PH_HDISCARD: begin
                n_bytes_left = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase         = shpd_pkg::PH_HEADER;
                    n_out_valid     = 1'b1;
                    n_kind          = shpd_pkg::KIND_RESYNC;
                    n_packet_length = r_cur_len;
                end
            end
            default: begin
                n_phase = shpd_pkg::PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= shpd_pkg::PH_HEADER;
            r_bytes_left <= 8'd0;
            r_cur_len    <= 8'd0;
            r_pos        <= 8'd0;
            r_out_valid  <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_cur_len    <= n_cur_len;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
        end else if (i_ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind          <= n_kind;
            r_payload_byte  <= n_payload_byte;
            r_byte_index    <= n_byte_index;
            r_last          <= n_last;
            r_packet_length <= n_packet_length;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_payload_byte  = r_payload_byte;
    assign o_byte_index    = r_byte_index;
    assign o_last          = r_last;
    assign o_packet_length = r_packet_length;

    assign out_payload = r_out_valid && (r_kind == shpd_pkg::KIND_PAYLOAD);
    assign out_empty   = r_out_valid && (r_kind == shpd_pkg::KIND_EMPTY);

    `SHPD_ASSERT_NOW(a_event_last, i_clk, i_rst_n, r_out_valid && !out_payload, r_last)
    `SHPD_ASSERT_NOW(a_index_in_len, i_clk, i_rst_n, out_payload, r_byte_index < r_packet_length)
    `SHPD_ASSERT_NOW(a_payload_left, i_clk, i_rst_n, r_phase == shpd_pkg::PH_PAYLOAD, |r_bytes_left)
    `SHPD_ASSERT_NOW(a_empty_len, i_clk, i_rst_n, out_empty, r_packet_length == 8'd0)
    `SHPD_ASSERT_NEXT(a_header_after_event, i_clk, i_rst_n, advance && n_out_valid && n_last, r_phase == shpd_pkg::PH_HEADER)

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [shpd_pkg::ADDR_W-1:0] ADDR_SYNC_BYTE =
        shpd_pkg::ADDR_W'(4 * shpd_pkg::REG_SYNC_BYTE);
    localparam logic [shpd_pkg::ADDR_W-1:0] ADDR_NO_REG    = shpd_pkg::ADDR_W'(4);
    localparam logic [7:0]        DIRECTED_SYNC  = 8'hA5;
    localparam int unsigned       RX_HOLD_CYCLES = 300;
    localparam int unsigned       WATCHDOG_LIMIT = 3000;
    localparam int unsigned       TAIL_CYCLES    = 8;

    typedef struct packed {
        shpd_pkg::t_kind kind;
        logic [7:0]      data;
        logic [7:0]      index;
        logic            last;
        logic [7:0]      length;
    } t_deframe_word;

    class deframe_scoreboard;
        logic [7:0]       sync_byte;
        shpd_pkg::t_phase phase;
        logic [7:0]       bytes_left;
        logic [7:0]       cur_length;
        logic [7:0]       position;
        t_deframe_word    pending_words[$];
        int unsigned      errors;

        function new();
            sync_byte  = 8'd0;
            phase      = shpd_pkg::PH_HEADER;
            bytes_left = 8'd0;
            cur_length = 8'd0;
            position   = 8'd0;
            errors     = 0;
        endfunction

        function void note_write(logic [shpd_pkg::ADDR_W-1:0] addr, logic [31:0] data);
            if (addr == ADDR_SYNC_BYTE) begin
                sync_byte = data[7:0];
            end
        endfunction

        function void queue_word(shpd_pkg::t_kind kind, logic [7:0] data, logic [7:0] index,
                                 logic last, logic [7:0] length);
            t_deframe_word w;
            w.kind   = kind;
            w.data   = data;
            w.index  = index;
            w.last   = last;
            w.length = length;
            pending_words.push_back(w);
        endfunction

        function void take_rx_byte(logic [7:0] b);
            logic hit;
            logic fin;
            hit = (b == sync_byte);
            case (phase)
                shpd_pkg::PH_HEADER: begin
                    phase = hit ? shpd_pkg::PH_LENGTH : shpd_pkg::PH_HUNT;
                end
                shpd_pkg::PH_LENGTH: begin
                    cur_length = b;
                    position   = 8'd0;
                    if (b == 8'd0) begin
                        phase = shpd_pkg::PH_HEADER;
                        queue_word(shpd_pkg::KIND_EMPTY, 8'd0, 8'd0, 1'b1, 8'd0);
                    end else begin
                        bytes_left = b;
                        phase      = shpd_pkg::PH_PAYLOAD;
                    end
                end
                shpd_pkg::PH_PAYLOAD: begin
                    fin = (bytes_left <= 8'd1);
                    queue_word(shpd_pkg::KIND_PAYLOAD, b, position, fin, cur_length);
                    position   = position + 8'd1;
                    bytes_left = bytes_left - 8'd1;
                    if (fin) begin
                        phase = shpd_pkg::PH_HEADER;
                    end
                end
                shpd_pkg::PH_HUNT: begin
                    if (hit) begin
                        phase = shpd_pkg::PH_HLEN;
                    end
                end
                shpd_pkg::PH_HLEN: begin
                    bytes_left = b;
                    phase      = (b == 8'd0) ? shpd_pkg::PH_HCHECK : shpd_pkg::PH_HSKIP;
                end
                shpd_pkg::PH_HSKIP: begin
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0) begin
                        phase = shpd_pkg::PH_HCHECK;
                    end
                end
                shpd_pkg::PH_HCHECK: begin
                    phase = hit ? shpd_pkg::PH_HLEN2 : shpd_pkg::PH_HUNT;
                end
                shpd_pkg::PH_HLEN2: begin
                    cur_length = b;
                    bytes_left = b;
                    if (b == 8'd0) begin
                        phase = shpd_pkg::PH_HEADER;
                        queue_word(shpd_pkg::KIND_RESYNC, 8'd0, 8'd0, 1'b1, 8'd0);
                    end else begin
                        phase = shpd_pkg::PH_HDISCARD;
                    end
                end
                shpd_pkg::PH_HDISCARD: begin
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0) begin
                        phase = shpd_pkg::PH_HEADER;
                        queue_word(shpd_pkg::KIND_RESYNC, 8'd0, 8'd0, 1'b1, cur_length);
                    end
                end
                default: begin
                    phase = shpd_pkg::PH_HEADER;
                end
            endcase
        endfunction

        function void check_word(t_deframe_word got);
            t_deframe_word want;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word kind=%0d data=%h index=%0d last=%0b length=%0d",
                         $time, got.kind, got.data, got.index, got.last, got.length);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got !== want) begin
                $display("%0t: word mismatch expected kind=%0d data=%h index=%0d last=%0b length=%0d",
                         $time, want.kind, want.data, want.index, want.last, want.length);
                $display("%0t:                  actual kind=%0d data=%h index=%0d last=%0b length=%0d",
                         $time, got.kind, got.data, got.index, got.last, got.length);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [7:0]                  i_rx_byte;
    logic                        o_valid;
    logic                        i_ready;
    logic [1:0]                  o_kind;
    logic [7:0]                  o_payload_byte;
    logic [7:0]                  o_byte_index;
    logic                        o_last;
    logic [7:0]                  o_packet_length;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [shpd_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    deframe_scoreboard sb = new();
    int unsigned       tx_idle_max;
    int unsigned       rx_idle_max;
    bit                rx_hold_req;
    int unsigned       bytes_sent;
    int unsigned       quiet_cycles;

    sync_hunting_packet_deframer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_byte_index    (o_byte_index),
        .o_last          (o_last),
        .o_packet_length (o_packet_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sample both channels on the edge where a word moves
    always @(posedge i_clk) begin
        t_deframe_word got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.take_rx_byte(i_rx_byte);
            end
            if (o_valid === 1'b1 && i_ready) begin
                got.kind   = o_kind;
                got.data   = o_payload_byte;
                got.index  = o_byte_index;
                got.last   = o_last;
                got.length = o_packet_length;
                sb.check_word(got);
            end
            if ((i_valid && o_ready) || (o_valid === 1'b1 && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // result side
    initial begin
        int unsigned gap;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            gap = $urandom_range(0, rx_idle_max);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_ready));
        end
    end

    task automatic apb_write(logic [shpd_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.note_write(addr, data);
    endtask

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_packet(logic [7:0] head, logic [7:0] length, int unsigned body);
        logic [7:0] b;
        send_byte(head);
        send_byte(length);
        for (int unsigned i = 0; i < body; i++) begin
            b = ($urandom_range(0, 7) == 0) ? sb.sync_byte : 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    // mostly well-formed packets, with noise, cut-short packets and bad headers
    task automatic run_traffic(int unsigned budget, bit with_longest);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  sync;
        stop_at = bytes_sent + budget;
        sync    = sb.sync_byte;
        if (with_longest) begin
            send_packet(sync, 8'd255, 255);
        end
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                len = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(1, 8);
            end
            if (pick < 70) begin
                send_packet(sync, 8'(len), len);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                send_packet(sync, 8'(len), $urandom_range(0, len));
            end else begin
                send_packet(sync ^ 8'($urandom_range(1, 255)), 8'(len), len);
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] directed[$] = '{
            DIRECTED_SYNC, 8'h00,
            DIRECTED_SYNC, 8'h02, 8'h00, 8'hFF,
            8'h11,
            DIRECTED_SYNC, 8'h00, 8'h22,
            DIRECTED_SYNC, 8'h01, 8'h33, DIRECTED_SYNC, 8'h00,
            8'h44,
            DIRECTED_SYNC, 8'h00, DIRECTED_SYNC, 8'h02, 8'h55, 8'h66,
            DIRECTED_SYNC, 8'h01, 8'hFF
        };
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_rx_byte    = 8'd0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = 32'd0;
        tx_idle_max  = 8;
        rx_idle_max  = 8;
        rx_hold_req  = 1'b0;
        bytes_sent   = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unmapped register is ignored
        apb_write(ADDR_NO_REG, 32'h0000_0033);
        apb_write(ADDR_SYNC_BYTE, {24'hFFFFFF, DIRECTED_SYNC});
        foreach (directed[i]) begin
            send_byte(directed[i]);
        end
        i_valid <= 1'b0;
        wait_drained();

        apb_write(ADDR_SYNC_BYTE, 32'h0000_0000);
        run_traffic(90, 1'b0);
        wait_drained();

        // no idling, longest packet
        tx_idle_max = 0;
        rx_idle_max = 0;
        apb_write(ADDR_SYNC_BYTE, 32'h0000_00FF);
        run_traffic(90, 1'b1);
        wait_drained();

        // long receiver stall while bytes keep coming
        rx_idle_max = 8;
        rx_hold_req = 1'b1;
        apb_write(ADDR_SYNC_BYTE, $urandom);
        run_traffic(90, 1'b0);
        wait_drained();

        tx_idle_max = 8;
        apb_write(ADDR_NO_REG, $urandom);
        apb_write(ADDR_SYNC_BYTE, $urandom);
        run_traffic(90, 1'b0);
        wait_drained();

        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
